### rtl/core/apu_pkg.sv
// Shared types and constants for the Adam parameter update block.
// No dependencies; every other file imports this package.
`default_nettype none

package apu_pkg;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_STEP_SIZE     = 2'd0;
    localparam logic [1:0] REG_BETA_ONE      = 2'd1;
    localparam logic [1:0] REG_BETA_TWO      = 2'd2;
    localparam logic [1:0] REG_STEP_COUNT    = 2'd3;

    // Reset values of the configuration registers
    localparam logic [23:0] LR_RESET    = 24'd16777;
    localparam logic [23:0] B1_RESET    = 24'd15099494;
    localparam logic [23:0] B2_RESET    = 24'd16760439;
    localparam logic [15:0] STEP_RESET  = 16'd1;

    localparam logic [24:0] ONE_Q24     = 25'h100_0000;
    localparam logic [47:0] MASK48      = 48'hFFFF_FFFF_FFFF;
    localparam logic [44:0] EPS_Q32     = 45'd43;        // 1e-8 in Q.32
    localparam logic [33:0] DELTA_MAX   = 34'h2_0000_0000;

    // Pipeline geometry of the back end
    localparam int SQ_STAGES = 44;   // one root bit per stage
    localparam int DV_STAGES = 34;   // one quotient bit per stage

    // Correction sequencer states
    typedef enum logic [2:0] {
        CS_START,
        CS_POW,
        CS_PREP,
        CS_DIV,
        CS_READY
    } corr_state_t;

    typedef struct packed {
        logic signed [31:0] param_value;
        logic signed [31:0] grad_value;
        logic signed [31:0] first_moment;
        logic        [47:0] second_moment;
    } apu_in_t;

    typedef struct packed {
        logic signed [31:0] new_param;
        logic signed [31:0] new_first_moment;
        logic        [47:0] new_second_moment;
        logic               saturated;
    } apu_out_t;

    // Bias corrections handed from the correction unit to the back end
    typedef struct packed {
        logic        ready;
        logic [47:0] corr_one;
        logic [47:0] corr_two;
    } apu_corr_t;

    // Per-element values that ride along the back-end pipeline
    typedef struct packed {
        logic [31:0] p;
        logic [31:0] m;
        logic [47:0] v;
        logic        neg;
        logic        sat;
        logic [79:0] num;
        logic [63:0] vh;
    } apu_carry_t;

endpackage

`default_nettype wire

### rtl/core/apu_corr.sv
// Bias correction unit: beta^t by square-and-multiply, then 2^64/(2^32-beta^t)
// by a bit-serial restoring divider. Depends on apu_pkg.
`default_nettype none

module apu_corr
    import apu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        restart,
    input  wire logic [23:0] beta_one,
    input  wire logic [23:0] beta_two,
    input  wire logic [15:0] step_count,
    output apu_corr_t        corr
);

    corr_state_t state_reg, state_next;
    logic [6:0]  iter_reg;
    logic [32:0] acc1_reg, acc2_reg;
    logic [31:0] base1_reg, base2_reg;
    logic [32:0] den1_reg, den2_reg;
    logic [32:0] rem1_reg, rem2_reg;
    logic [47:0] q1_reg, q2_reg;
    logic        ovf1_reg, ovf2_reg;

    logic [64:0] am1, am2;
    logic [63:0] bb1, bb2;
    logic [31:0] pw1, pw2;
    logic        nbit;
    logic [33:0] rn1, rn2;

    // square-and-multiply products
    assign am1 = acc1_reg * base1_reg;
    assign am2 = acc2_reg * base2_reg;
    assign bb1 = base1_reg * base1_reg;
    assign bb2 = base2_reg * base2_reg;

    // clamp of beta^t to Q0.32
    assign pw1 = acc1_reg[32] ? 32'hFFFF_FFFF : acc1_reg[31:0];
    assign pw2 = acc2_reg[32] ? 32'hFFFF_FFFF : acc2_reg[31:0];

    // numerator 2^64 has only its top bit set
    assign nbit = (iter_reg == 7'd64);
    assign rn1  = {rem1_reg, nbit};
    assign rn2  = {rem2_reg, nbit};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CS_START: state_next = CS_POW;
            CS_POW:   if (iter_reg == 7'd15) state_next = CS_PREP;
            CS_PREP:  state_next = CS_DIV;
            CS_DIV:   if (iter_reg == 7'd0) state_next = CS_READY;
            CS_READY: state_next = CS_READY;
            default:  state_next = CS_START;
        endcase
        if (restart)
            state_next = CS_START;
    end

    // outputs
    always_comb
    begin
        corr.ready    = (state_reg == CS_READY);
        corr.corr_one = ovf1_reg ? MASK48 : q1_reg;
        corr.corr_two = ovf2_reg ? MASK48 : q2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= CS_START;
        else
            state_reg <= state_next;
    end

    // datapath of the sequencer
    always_ff @(posedge clk)
    begin
        case (state_reg)
            CS_START:
            begin
                acc1_reg  <= 33'h1_0000_0000;
                acc2_reg  <= 33'h1_0000_0000;
                base1_reg <= {beta_one, 8'h00};
                base2_reg <= {beta_two, 8'h00};
                iter_reg  <= 7'd0;
            end
            CS_POW:
            begin
                if (step_count[iter_reg[3:0]])
                begin
                    acc1_reg <= am1[64:32];
                    acc2_reg <= am2[64:32];
                end
                base1_reg <= bb1[63:32];
                base2_reg <= bb2[63:32];
                iter_reg  <= iter_reg + 7'd1;
            end
            CS_PREP:
            begin
                den1_reg <= 33'h1_0000_0000 - {1'b0, pw1};
                den2_reg <= 33'h1_0000_0000 - {1'b0, pw2};
                rem1_reg <= '0;
                rem2_reg <= '0;
                q1_reg   <= '0;
                q2_reg   <= '0;
                ovf1_reg <= 1'b0;
                ovf2_reg <= 1'b0;
                iter_reg <= 7'd64;
            end
            CS_DIV:
            begin
                ovf1_reg <= ovf1_reg | q1_reg[47];
                ovf2_reg <= ovf2_reg | q2_reg[47];
                if (rn1 >= {1'b0, den1_reg})
                begin
                    rem1_reg <= 33'(rn1 - {1'b0, den1_reg});
                    q1_reg   <= {q1_reg[46:0], 1'b1};
                end
                else
                begin
                    rem1_reg <= rn1[32:0];
                    q1_reg   <= {q1_reg[46:0], 1'b0};
                end
                if (rn2 >= {1'b0, den2_reg})
                begin
                    rem2_reg <= 33'(rn2 - {1'b0, den2_reg});
                    q2_reg   <= {q2_reg[46:0], 1'b1};
                end
                else
                begin
                    rem2_reg <= rn2[32:0];
                    q2_reg   <= {q2_reg[46:0], 1'b0};
                end
                iter_reg <= iter_reg - 7'd1;
            end
            default:
            begin
                iter_reg <= iter_reg;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/apu_fifo.sv
// Short queue of accepted items between the front end and the back end.
// Depends on apu_pkg for the item type.
`default_nettype none

module apu_fifo
    import apu_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  apu_in_t   push_data,
    input  wire logic pop,
    output apu_in_t   head,
    output logic      empty,
    output logic      full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    apu_in_t        mem [0:DEPTH-1];
    logic [AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]  count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CW'(DEPTH));
    assign head  = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            if (push && !pop)
                count_reg <= count_reg + CW'(1);
            else if (pop && !push)
                count_reg <= count_reg - CW'(1);
        end
    end

endmodule

`default_nettype wire

### rtl/core/apu_back.sv
// Back end: moment updates, bias scaling, pipelined square root and divider,
// parameter step and output register. Depends on apu_pkg.
`default_nettype none

module apu_back
    import apu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  apu_in_t          head,
    input  wire logic        head_valid,
    output logic             pop,
    input  wire logic [23:0] step_size,
    input  wire logic [23:0] beta_one,
    input  wire logic [23:0] beta_two,
    input  apu_corr_t        corr,
    output logic             result_valid,
    input  wire logic        result_stall,
    output apu_out_t         result_data
);

    logic en;
    logic out_vld_reg;
    apu_out_t result_reg;

    assign en           = !out_vld_reg || !result_stall;
    assign pop          = en && head_valid;
    assign result_valid = out_vld_reg;
    assign result_data  = result_reg;

    // ---------------- stage 1: first products ----------------
    logic              s1_vld_reg;
    apu_carry_t        s1_c_reg;
    logic signed [57:0] s1_m1_reg, s1_m2_reg;
    logic [63:0]       s1_gg_reg;
    logic [47:0]       s1_bvl_reg, s1_bvh_reg;

    logic [24:0]        nb1, nb2;
    logic signed [57:0] m1_w, m2_w;
    logic [31:0]        gmag;
    apu_carry_t         s1_c;

    assign nb1  = ONE_Q24 - {1'b0, beta_one};
    assign nb2  = ONE_Q24 - {1'b0, beta_two};
    assign m1_w = $signed({1'b0, beta_one}) * $signed(head.first_moment);
    assign m2_w = $signed({1'b0, nb1}) * $signed(head.grad_value);
    assign gmag = head.grad_value[31] ? (~head.grad_value + 32'd1) : head.grad_value;

    // carry fields entering the pipeline
    always_comb
    begin
        s1_c     = '0;
        s1_c.p   = head.param_value;
        s1_c.v   = head.second_moment;
        s1_c.sat = (corr.corr_one == MASK48) || (corr.corr_two == MASK48);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_c_reg     <= s1_c;
            s1_m1_reg    <= m1_w;
            s1_m2_reg    <= m2_w;
            s1_gg_reg    <= gmag * gmag;
            s1_bvl_reg   <= beta_two * head.second_moment[23:0];
            s1_bvh_reg   <= beta_two * head.second_moment[47:24];
        end
    end

    // ---------------- stage 2: first moment, g^2 products ----------------
    logic              s2_vld_reg;
    apu_carry_t        s2_c_reg;
    logic [71:0]       s2_bv_reg;
    logic [52:0]       s2_gql_reg, s2_gqh_reg;

    logic signed [58:0] msum;
    logic [34:0]        mraw;
    logic               mclip;
    logic [55:0]        gsq;
    apu_carry_t         s2_c;

    assign msum  = s1_m1_reg + s1_m2_reg;
    assign mraw  = msum[58:24];
    assign mclip = !((mraw[34:31] == 4'b0000) || (mraw[34:31] == 4'b1111));
    assign gsq   = s1_gg_reg[63:8];

    // clamped first moment into the carry
    always_comb
    begin
        s2_c     = s1_c_reg;
        s2_c.m   = mclip ? (mraw[34] ? 32'h8000_0000 : 32'h7FFF_FFFF) : mraw[31:0];
        s2_c.sat = s1_c_reg.sat | mclip;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_c_reg     <= s2_c;
            s2_bv_reg    <= {24'h0, s1_bvl_reg} + {s1_bvh_reg, 24'h0};
            s2_gql_reg   <= nb2 * gsq[27:0];
            s2_gqh_reg   <= nb2 * gsq[55:28];
        end
    end

    // ---------------- stage 3: second moment, m * c1 products ----------------
    logic              s3_vld_reg;
    apu_carry_t        s3_c_reg;
    logic [55:0]       s3_mcl_reg, s3_mch_reg;

    logic [81:0] vfull;
    logic [57:0] vs;
    logic        vclip;
    logic [31:0] mmag;
    apu_carry_t  s3_c;

    assign vfull = {10'h0, s2_bv_reg} + {29'h0, s2_gql_reg} + {1'b0, s2_gqh_reg, 28'h0};
    assign vs    = vfull[81:24];
    assign vclip = |vs[57:48];
    assign mmag  = s2_c_reg.m[31] ? (~s2_c_reg.m + 32'd1) : s2_c_reg.m;

    // clamped second moment and sign of the step into the carry
    always_comb
    begin
        s3_c     = s2_c_reg;
        s3_c.v   = vclip ? MASK48 : vs[47:0];
        s3_c.neg = s2_c_reg.m[31];
        s3_c.sat = s2_c_reg.sat | vclip;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_c_reg     <= s3_c;
            s3_mcl_reg   <= mmag * corr.corr_one[23:0];
            s3_mch_reg   <= mmag * corr.corr_one[47:24];
        end
    end

    // ---------------- stage 4: m_hat, v * c2 products ----------------
    logic              s4_vld_reg;
    apu_carry_t        s4_c_reg;
    logic [47:0]       s4_mh_reg;
    logic [47:0]       s4_vc0_reg, s4_vc1_reg, s4_vc2_reg, s4_vc3_reg;

    logic [79:0] mprod;
    assign mprod = {24'h0, s3_mcl_reg} + {s3_mch_reg, 24'h0};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_c_reg   <= s3_c_reg;
            s4_mh_reg  <= mprod[79:32];
            s4_vc0_reg <= s3_c_reg.v[23:0] * corr.corr_two[23:0];
            s4_vc1_reg <= s3_c_reg.v[23:0] * corr.corr_two[47:24];
            s4_vc2_reg <= s3_c_reg.v[47:24] * corr.corr_two[23:0];
            s4_vc3_reg <= s3_c_reg.v[47:24] * corr.corr_two[47:24];
        end
    end

    // ---------------- stage 5: v_hat, lr * m_hat products ----------------
    logic              s5_vld_reg;
    apu_carry_t        s5_c_reg;
    logic [47:0]       s5_lml_reg, s5_lmh_reg;

    logic [95:0] vprod;
    apu_carry_t  s5_c;
    assign vprod = {48'h0, s4_vc0_reg} + {24'h0, s4_vc1_reg, 24'h0}
                 + {24'h0, s4_vc2_reg, 24'h0} + {s4_vc3_reg, 48'h0};

    // v_hat into the carry
    always_comb
    begin
        s5_c    = s4_c_reg;
        s5_c.vh = vprod[95:32];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_c_reg    <= s5_c;
            s5_lml_reg  <= step_size * s4_mh_reg[23:0];
            s5_lmh_reg  <= step_size * s4_mh_reg[47:24];
        end
    end

    // ---------------- stage 6: numerator, root pipeline entry ----------------
    logic       sq_vld  [0:SQ_STAGES];
    apu_carry_t sq_c    [0:SQ_STAGES];
    logic [44:0] sq_rem [0:SQ_STAGES];
    logic [43:0] sq_root[0:SQ_STAGES];

    logic [71:0] lm;
    apu_carry_t  sq_in;
    assign lm = {24'h0, s5_lml_reg} + {s5_lmh_reg, 24'h0};

    // divider numerator into the carry
    always_comb
    begin
        sq_in     = s5_c_reg;
        sq_in.num = {lm, 8'h00};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_c[0]     <= sq_in;
            sq_rem[0]   <= '0;
            sq_root[0]  <= '0;
        end
    end

    // valid bits of the front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            sq_vld[0]  <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= head_valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
            sq_vld[0]  <= s5_vld_reg;
        end
    end

    // ---------------- square root of v_hat * 2^24, one bit per stage ----------------
    for (genvar i = 0; i < SQ_STAGES; i++)
    begin : g_sqrt
        localparam int K = SQ_STAGES - 1 - i;
        logic [1:0]  pair;
        logic [46:0] rem_n, trial;

        if (2 * K >= 24)
        begin : g_bits
            assign pair = sq_c[i].vh[2*K-23 -: 2];
        end
        else
        begin : g_zero
            assign pair = 2'b00;
        end

        assign rem_n = {sq_rem[i], pair};
        assign trial = {1'b0, sq_root[i], 2'b01};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_vld[i+1] <= 1'b0;
            else if (en)
                sq_vld[i+1] <= sq_vld[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_c[i+1] <= sq_c[i];
                if (rem_n >= trial)
                begin
                    sq_rem[i+1]  <= 45'(rem_n - trial);
                    sq_root[i+1] <= {sq_root[i][42:0], 1'b1};
                end
                else
                begin
                    sq_rem[i+1]  <= rem_n[44:0];
                    sq_root[i+1] <= {sq_root[i][42:0], 1'b0};
                end
            end
        end
    end

    // ---------------- divider entry: denominator and range check ----------------
    logic        dv_vld [0:DV_STAGES];
    apu_carry_t  dv_c   [0:DV_STAGES];
    logic [44:0] dv_rem [0:DV_STAGES];
    logic [44:0] dv_den [0:DV_STAGES];
    logic [33:0] dv_q   [0:DV_STAGES];
    logic        dv_ovf [0:DV_STAGES];

    logic [44:0] den;
    assign den = {1'b0, sq_root[SQ_STAGES]} + EPS_Q32;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_vld[0] <= 1'b0;
        else if (en)
            dv_vld[0] <= sq_vld[SQ_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_c[0]   <= sq_c[SQ_STAGES];
            dv_den[0] <= den;
            dv_ovf[0] <= sq_c[SQ_STAGES].num[79:34] >= {1'b0, den};
            dv_rem[0] <= sq_c[SQ_STAGES].num[78:34];
            dv_q[0]   <= '0;
        end
    end

    // ---------------- restoring divider, one quotient bit per stage ----------------
    for (genvar j = 0; j < DV_STAGES; j++)
    begin : g_div
        localparam int B = DV_STAGES - 1 - j;
        logic [45:0] rem_n;

        assign rem_n = {dv_rem[j], dv_c[j].num[B]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_vld[j+1] <= 1'b0;
            else if (en)
                dv_vld[j+1] <= dv_vld[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_c[j+1]   <= dv_c[j];
                dv_den[j+1] <= dv_den[j];
                dv_ovf[j+1] <= dv_ovf[j];
                if (rem_n >= {1'b0, dv_den[j]})
                begin
                    dv_rem[j+1] <= 45'(rem_n - {1'b0, dv_den[j]});
                    dv_q[j+1]   <= {dv_q[j][32:0], 1'b1};
                end
                else
                begin
                    dv_rem[j+1] <= rem_n[44:0];
                    dv_q[j+1]   <= {dv_q[j][32:0], 1'b0};
                end
            end
        end
    end

    // ---------------- parameter step and output register ----------------
    apu_carry_t         fc;
    logic [33:0]        delta;
    logic signed [34:0] pw, dw, pnew;
    logic               pclip;

    assign fc    = dv_c[DV_STAGES];
    assign delta = (dv_ovf[DV_STAGES] || (dv_q[DV_STAGES] > DELTA_MAX))
                   ? DELTA_MAX : dv_q[DV_STAGES];
    assign pw    = $signed({{3{fc.p[31]}}, fc.p});
    assign dw    = $signed({1'b0, delta});
    assign pnew  = fc.neg ? (pw + dw) : (pw - dw);
    assign pclip = !((pnew[34:31] == 4'b0000) || (pnew[34:31] == 4'b1111));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= dv_vld[DV_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg.new_param         <= pclip ? (pnew[34] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                                                  : pnew[31:0];
            result_reg.new_first_moment  <= fc.m;
            result_reg.new_second_moment <= fc.v;
            result_reg.saturated         <= fc.sat | pclip;
        end
    end

endmodule

`default_nettype wire

### rtl/core/adam_parameter_update_top.sv
// An accepted transfer passes through the queue, then 6 arithmetic stages, a 44-stage
// root pipeline, a 35-stage divider and the output register before its result appears.
// Throughput: one element per cycle; the whole back end advances as one pipeline
// and freezes while the output transfer is stalled, the queue absorbing input.
// Reset, and any write of beta_one, beta_two or step_count, start the correction
// unit: 16 square-and-multiply steps, then 65 divide steps, with input stalled.
`default_nettype none

module adam_parameter_update_top
    import apu_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  apu_in_t          item_data,
    output logic             result_valid,
    input  wire logic        result_stall,
    output apu_out_t         result_data,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);

    logic [23:0] lr_reg, b1_reg, b2_reg;
    logic [15:0] step_reg;
    logic        restart;
    apu_corr_t   corr;
    apu_in_t     head;
    logic        q_empty, q_full, q_pop, push;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg   <= LR_RESET;
            b1_reg   <= B1_RESET;
            b2_reg   <= B2_RESET;
            step_reg <= STEP_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_STEP_SIZE:     lr_reg   <= cfg_data;
                REG_BETA_ONE:      b1_reg   <= cfg_data;
                REG_BETA_TWO:      b2_reg   <= cfg_data;
                REG_STEP_COUNT:    step_reg <= cfg_data[15:0];
                default:           lr_reg   <= lr_reg;
            endcase
        end
    end

    assign restart = cfg_write &&
                     (cfg_index inside {REG_BETA_ONE, REG_BETA_TWO, REG_STEP_COUNT});

    // front end: hold off transfers until corrections are ready and the queue has room
    assign item_stall = q_full || !corr.ready;
    assign push       = item_valid && !item_stall;

    apu_corr u_corr (
        .clk        (clk),
        .rst_n      (rst_n),
        .restart    (restart),
        .beta_one   (b1_reg),
        .beta_two   (b2_reg),
        .step_count (step_reg),
        .corr       (corr)
    );

    apu_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (item_data),
        .pop       (q_pop),
        .head      (head),
        .empty     (q_empty),
        .full      (q_full)
    );

    apu_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .head_valid    (!q_empty),
        .pop           (q_pop),
        .step_size     (lr_reg),
        .beta_one      (b1_reg),
        .beta_two      (b2_reg),
        .corr          (corr),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result_data   (result_data)
    );

endmodule

`default_nettype wire
